FILE: sv/mipmap_downsample_filter_macros.svh
// Assertion macros shared by the mipmap downsample filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MIPMAP_DOWNSAMPLE_FILTER_MACROS_SVH
`define MIPMAP_DOWNSAMPLE_FILTER_MACROS_SVH

// same-cycle implication
`define MDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define MDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: sv/mdf_pkg.sv
// Types, codes and channel slicing functions for the mipmap downsample filter.
// No dependencies; used by mdf_lane, mdf_merge and the top level.
package mdf_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumTaps  = 9;
  localparam int unsigned PixW     = 64;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned RowSumW  = 18;
  localparam int unsigned SumW     = 20;

  localparam logic [3:0] FMT_8888     = 4'd0;
  localparam logic [3:0] FMT_565      = 4'd1;
  localparam logic [3:0] FMT_4444     = 4'd2;
  localparam logic [3:0] FMT_8        = 4'd3;
  localparam logic [3:0] FMT_88       = 4'd4;
  localparam logic [3:0] FMT_16       = 4'd5;
  localparam logic [3:0] FMT_1616     = 4'd6;
  localparam logic [3:0] FMT_16161616 = 4'd7;
  localparam logic [3:0] FMT_1010102  = 4'd8;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // encoding equals log2 of the tap weight sum
  typedef enum logic [1:0] {
    TAP_ONE  = 2'd0,
    TAP_BOX  = 2'd1,
    TAP_TENT = 2'd2
  } tap_e;

  typedef struct packed {
    logic [3:0] fmt;
    tap_e       hmode;
    tap_e       vmode;
  } cfg_t;

  function automatic tap_e tap_mode(logic [15:0] size);
    tap_e m;
    if (size == 16'd1) begin
      m = TAP_ONE;
    end else if (!size[0]) begin
      m = TAP_BOX;
    end else begin
      m = TAP_TENT;
    end
    return m;
  endfunction

  function automatic logic [ChanW-1:0] chan_get(logic [3:0] fmt, logic [1:0] lane,
                                               logic [PixW-1:0] pix);
    logic [ChanW-1:0] v;
    v = '0;
    case (fmt)
      FMT_8888: v = {8'd0, pix[{lane, 3'b000} +: 8]};
      FMT_565: begin
        case (lane)
          2'd0:    v = {11'd0, pix[4:0]};
          2'd1:    v = {10'd0, pix[10:5]};
          2'd2:    v = {11'd0, pix[15:11]};
          default: v = '0;
        endcase
      end
      FMT_4444: v = {12'd0, pix[{lane, 2'b00} +: 4]};
      FMT_8:    v = (lane == 2'd0) ? {8'd0, pix[7:0]} : '0;
      FMT_88:   v = (!lane[1]) ? {8'd0, pix[{lane[0], 3'b000} +: 8]} : '0;
      FMT_16:   v = (lane == 2'd0) ? pix[15:0] : '0;
      FMT_1616: v = (!lane[1]) ? pix[{lane[0], 4'b0000} +: 16] : '0;
      FMT_16161616: v = pix[{lane, 4'b0000} +: 16];
      FMT_1010102: begin
        case (lane)
          2'd0:    v = {6'd0, pix[9:0]};
          2'd1:    v = {6'd0, pix[19:10]};
          2'd2:    v = {6'd0, pix[29:20]};
          default: v = {14'd0, pix[31:30]};
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [PixW-1:0] chan_put(logic [3:0] fmt, logic [1:0] lane,
                                              logic [ChanW-1:0] v);
    logic [PixW-1:0] p;
    p = '0;
    case (fmt)
      FMT_8888: p[{lane, 3'b000} +: 8] = v[7:0];
      FMT_565: begin
        case (lane)
          2'd0:    p[4:0]   = v[4:0];
          2'd1:    p[10:5]  = v[5:0];
          2'd2:    p[15:11] = v[4:0];
          default: p = '0;
        endcase
      end
      FMT_4444: p[{lane, 2'b00} +: 4] = v[3:0];
      FMT_8: begin
        if (lane == 2'd0) p[7:0] = v[7:0];
      end
      FMT_88: begin
        if (!lane[1]) p[{lane[0], 3'b000} +: 8] = v[7:0];
      end
      FMT_16: begin
        if (lane == 2'd0) p[15:0] = v;
      end
      FMT_1616: begin
        if (!lane[1]) p[{lane[0], 4'b0000} +: 16] = v;
      end
      FMT_16161616: p[{lane, 4'b0000} +: 16] = v;
      FMT_1010102: begin
        case (lane)
          2'd0:    p[9:0]   = v[9:0];
          2'd1:    p[19:10] = v[9:0];
          2'd2:    p[29:20] = v[9:0];
          default: p[31:30] = v[1:0];
        endcase
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/mdf_lane.sv
// One channel lane: extracts its channel from the 3x3 window, registers the
// weighted row sums, then forms the column sum and the floor average. Uses mdf_pkg.
module mdf_lane #(
  parameter logic [1:0] Lane = 2'd0
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  mdf_pkg::cfg_t                       cfg_i,
  input  logic [mdf_pkg::NumTaps-1:0][63:0]   pix_i,
  output logic [mdf_pkg::ChanW-1:0]           avg_o
);
  import mdf_pkg::*;

  logic [2:0][RowSumW-1:0] hsum_d, hsum_q;
  logic [SumW-1:0]         vsum;
  logic [SumW-1:0]         shifted;
  logic [2:0]              shift;

  always_comb begin
    logic [ChanW-1:0] c0, c1, c2;
    for (int r = 0; r < 3; r++) begin
      c0 = chan_get(cfg_i.fmt, Lane, pix_i[r*3]);
      c1 = chan_get(cfg_i.fmt, Lane, pix_i[r*3+1]);
      c2 = chan_get(cfg_i.fmt, Lane, pix_i[r*3+2]);
      hsum_d[r] = {2'b00, c0};
      if (cfg_i.hmode == TAP_BOX) begin
        hsum_d[r] = hsum_d[r] + {2'b00, c1};
      end else if (cfg_i.hmode == TAP_TENT) begin
        hsum_d[r] = hsum_d[r] + {1'b0, c1, 1'b0} + {2'b00, c2};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) hsum_q <= hsum_d;
  end

  always_comb begin
    vsum = {2'b00, hsum_q[0]};
    if (cfg_i.vmode == TAP_BOX) begin
      vsum = vsum + {2'b00, hsum_q[1]};
    end else if (cfg_i.vmode == TAP_TENT) begin
      vsum = vsum + {1'b0, hsum_q[1], 1'b0} + {2'b00, hsum_q[2]};
    end
    shift   = {1'b0, cfg_i.hmode} + {1'b0, cfg_i.vmode};
    shifted = vsum >> shift;
    avg_o   = shifted[ChanW-1:0];
  end

endmodule

FILE: sv/mdf_merge.sv
// Merge stage: packs the lane averages into one pixel of the selected format
// and holds it in the output register. Uses mdf_pkg.
module mdf_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic                                          ready_i,
  input  logic [3:0]                                    fmt_i,
  input  logic [mdf_pkg::NumLanes-1:0][mdf_pkg::ChanW-1:0] avg_i,
  output logic                                          advance_o,
  output logic                                          valid_o,
  output logic [mdf_pkg::PixW-1:0]                      data_o
);
  import mdf_pkg::*;

  logic            valid_d, valid_q;
  logic [PixW-1:0] data_d, data_q;

  always_comb begin
    data_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      data_d = data_d | chan_put(fmt_i, l[1:0], avg_i[l]);
    end
  end

  assign advance_o = !valid_q || ready_i;
  assign valid_d   = advance_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/mipmap_downsample_filter.sv
// Pipeline: row-sum register, then output register; four channel lanes work on each
// window at once. Throughput: one request per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears both valid flags and loads the
// registers with format 8888 and a 2x2 source size.
// Uses mdf_pkg, mdf_lane, mdf_merge and the assertion macro header.
`include "mipmap_downsample_filter_macros.svh"
module mipmap_downsample_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2; 64 bits each
  input  logic [575:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dest_pixel
  output logic [63:0]  m_axis_tdata
);
  import mdf_pkg::*;

  logic [3:0]  fmt_q;
  logic [15:0] width_q, height_q;
  logic        wr_en;
  cfg_t        cfg;
  logic        s1_valid_d, s1_valid_q;
  logic        advance;
  logic        load;
  logic [NumTaps-1:0][PixW-1:0]    pix;
  logic [NumLanes-1:0][ChanW-1:0]  avg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_8888;
      width_q  <= 16'd2;
      height_q <= 16'd2;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FORMAT: fmt_q    <= pwdata[3:0];
        REG_WIDTH:  width_q  <= pwdata[15:0];
        REG_HEIGHT: height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FORMAT: prdata = {28'd0, fmt_q};
      REG_WIDTH:  prdata = {16'd0, width_q};
      REG_HEIGHT: prdata = {16'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.fmt   = fmt_q;
    cfg.hmode = tap_mode(width_q);
    cfg.vmode = tap_mode(height_q);
  end

  always_comb begin
    for (int k = 0; k < NumTaps; k++) begin
      pix[k] = s_axis_tdata[k*PixW +: PixW];
    end
  end

  assign s_axis_tready = !s1_valid_q || advance;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = s_axis_tready ? s_axis_tvalid : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    mdf_lane #(
      .Lane(l[1:0])
    ) u_lane (
      .clk_i  (clk_i),
      .load_i (load),
      .cfg_i  (cfg),
      .pix_i  (pix),
      .avg_o  (avg[l])
    );
  end

  mdf_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .ready_i   (m_axis_tready),
    .fmt_i     (fmt_q),
    .avg_i     (avg),
    .advance_o (advance),
    .valid_o   (m_axis_tvalid),
    .data_o    (m_axis_tdata)
  );

  // stalled row sums must not be dropped
  `MDF_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !advance, s1_valid_q)
  // an accepted request always lands in the row-sum stage
  `MDF_ASSERT_NXT(a_s1_load, clk_i, rst_ni, load, s1_valid_q)
  // a new result only comes from a filled row-sum stage
  `MDF_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s1_valid_q))
  // with the output free the input side never stalls
  `MDF_ASSERT_IMP(a_no_bubble, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

FILE: tb/mipmap_downsample_filter_tb.sv
// Self-checking testbench for mipmap_downsample_filter: 3x3 windows in, one pixel out.
// A scoreboard class predicts each filtered pixel from its own copy of the registers.
// Depends on mdf_pkg and the mipmap_downsample_filter RTL.
`timescale 1ns / 1ps
module mipmap_downsample_filter_tb;
  import mdf_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandItems  = 1500;

  class pixel_scoreboard;
    logic [3:0]  fmt;
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic [63:0] expected_pixels[$];
    int          errors;
    int          checked;

    function new();
      fmt     = FMT_8888;
      src_w   = 16'd2;
      src_h   = 16'd2;
      errors  = 0;
      checked = 0;
    endfunction

    function tap_e taps(logic [15:0] size);
      if (size == 16'd1) return TAP_ONE;
      if (!size[0]) return TAP_BOX;
      return TAP_TENT;
    endfunction

    function logic [63:0] downsample(logic [575:0] win);
      tap_e        hm;
      tap_e        vm;
      int unsigned hw[3];
      int unsigned vw[3];
      int unsigned sum;
      int unsigned pos;
      int unsigned bits;
      int unsigned shift;
      logic [63:0] mask;
      logic [63:0] src_pix;
      logic [63:0] result;
      hm = taps(src_w);
      vm = taps(src_h);
      hw[0] = 1;
      hw[1] = (hm == TAP_ONE) ? 0 : (hm == TAP_BOX) ? 1 : 2;
      hw[2] = (hm == TAP_TENT) ? 1 : 0;
      vw[0] = 1;
      vw[1] = (vm == TAP_ONE) ? 0 : (vm == TAP_BOX) ? 1 : 2;
      vw[2] = (vm == TAP_TENT) ? 1 : 0;
      // tap mode encoding is log2 of the weight sum
      shift  = 32'(hm) + 32'(vm);
      result = '0;
      for (int ch = 0; ch < 4; ch++) begin
        pos  = 0;
        bits = 0;
        case (fmt)
          FMT_8888: begin
            pos  = 8 * ch;
            bits = 8;
          end
          FMT_565: begin
            pos  = (ch == 0) ? 0 : (ch == 1) ? 5 : 11;
            bits = (ch == 1) ? 6 : (ch < 3) ? 5 : 0;
          end
          FMT_4444: begin
            pos  = 4 * ch;
            bits = 4;
          end
          FMT_8: bits = (ch == 0) ? 8 : 0;
          FMT_88: begin
            pos  = 8 * ch;
            bits = (ch < 2) ? 8 : 0;
          end
          FMT_16: bits = (ch == 0) ? 16 : 0;
          FMT_1616: begin
            pos  = 16 * ch;
            bits = (ch < 2) ? 16 : 0;
          end
          FMT_16161616: begin
            pos  = 16 * ch;
            bits = 16;
          end
          FMT_1010102: begin
            pos  = 10 * ch;
            bits = (ch == 3) ? 2 : 10;
          end
          default: bits = 0;
        endcase
        if (bits != 0) begin
          mask = (64'd1 << bits) - 64'd1;
          sum  = 0;
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              src_pix = win[(r * 3 + c) * 64 +: 64];
              sum += hw[c] * vw[r] * 32'((src_pix >> pos) & mask);
            end
          end
          result |= ((64'(sum) >> shift) & mask) << pos;
        end
      end
      return result;
    endfunction

    function void note_window(logic [575:0] win);
      expected_pixels.push_back(downsample(win));
    endfunction

    function void check_pixel(logic [63:0] got);
      logic [63:0] exp_pix;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected dest_pixel %h", $time, got);
        errors++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        checked++;
        if (got !== exp_pix) begin
          $display("%0t: dest_pixel mismatch, expected %h, actual %h", $time, exp_pix, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [3:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [575:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;

  pixel_scoreboard sb = new();
  int unsigned     cycle_cnt = 0;
  int              rx_hold   = 0;
  bit              rx_idle_en = 1'b0;
  bit              tx_idle_en = 1'b0;
  int              sent      = 0;
  int              settings  = 0;

  mipmap_downsample_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [575:0] make_window();
    logic [575:0] win;
    int           r;
    for (int k = 0; k < 9; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) win[k * 64 +: 64] = '1;
      else if (r == 1) win[k * 64 +: 64] = '0;
      else win[k * 64 +: 64] = {$urandom, $urandom};
    end
    return win;
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd3;
      3: return 16'hFFFF;
      4: return 16'hFFFE;
      5: return {15'($urandom_range(1, 32767)), 1'b0};
      6: return {15'($urandom_range(1, 32767)), 1'b1};
      7: return 16'd0;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) rx_hold <= gap_len();
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FORMAT: sb.fmt   = value[3:0];
      REG_WIDTH:  sb.src_w = value[15:0];
      REG_HEIGHT: sb.src_h = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [3:0] fmt, input logic [15:0] w, input logic [15:0] h);
    cfg_write(REG_FORMAT, {8'($urandom_range(0, 255)), 24'd0} | 32'(fmt));
    cfg_write(REG_WIDTH, {16'($urandom), w});
    cfg_write(REG_HEIGHT, {16'($urandom), h});
    settings++;
  endtask

  task automatic send_window(input logic [575:0] win, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= win;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_window(win);
    sent++;
  endtask

  // sender holds off until every outstanding request has its result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [3:0]  dir_fmt[11];
    logic [15:0] dir_w[11];
    logic [15:0] dir_h[11];
    int          n;
    dir_fmt = '{FMT_8888, FMT_565, FMT_4444, FMT_8, FMT_88, FMT_16, FMT_1616,
                FMT_16161616, FMT_1010102, 4'd9, 4'd15};
    dir_w   = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFE, 16'd0, 16'd1, 16'd3, 16'd2,
                16'hFFFF, 16'd4};
    dir_h   = '{16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd1, 16'd0, 16'd3, 16'd3, 16'd2,
                16'd0, 16'd5};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: 8888, 2x2 box
    send_window('0, 0);
    send_window('1, 0);
    drain();
    // every format plus unknown codes, size extremes including zero and 1x1
    for (int i = 0; i < 11; i++) begin
      set_filter(dir_fmt[i], dir_w[i], dir_h[i]);
      send_window('1, 0);
      send_window(make_window(), 0);
      drain();
    end

    while (sent < RandItems + 24) begin
      if ($urandom_range(0, 9) == 0) set_filter(4'($urandom_range(9, 15)), pick_size(), pick_size());
      else set_filter(4'($urandom_range(0, 8)), pick_size(), pick_size());
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 120);
      for (int k = 0; k < n; k++) begin
        send_window(make_window(),
                    (tx_idle_en && $urandom_range(0, 2) == 0) ? gap_len() : 0);
      end
      drain();
    end
    rx_idle_en = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d windows over %0d register settings; %0d pixels checked.",
             sent, settings, sb.checked);
    $display("Covered all nine formats, unknown format codes and tap sizes 0 to 65535.");
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/mdf_pkg.sv
sv/mdf_lane.sv
sv/mdf_merge.sv
sv/mipmap_downsample_filter.sv
tb/mipmap_downsample_filter_tb.sv
